// ===== src/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and constants for linear blend vertex skinning
// Palette geometry, fixed-point helpers and sequencer states.
// ----------------------------------------------------------------------------
package lbs_pkg;

   localparam int MAX_BONES   = 128;
   localparam int SLOT_W      = $clog2(MAX_BONES);
   localparam int PAL_DEPTH   = MAX_BONES * 16;
   localparam int PAL_AW      = $clog2(PAL_DEPTH);
   localparam int WORD_W      = 32;
   localparam int ID_W        = 7;
   localparam int OACC_W      = 50;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_SKIN  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_XFORM,
      ST_FINISH,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [OACC_W-1:0] v);
      if (v > OACC_W'(32'sh7fffffff))
         return 32'sh7fffffff;
      else if (v < OACC_W'(32'sh80000000))
         return 32'sh80000000;
      else
         return v[31:0];
   endfunction

endpackage

// ===== src/lbs_ram.sv =====
// ----------------------------------------------------------------------------
// lbs_ram: generic single-port write, single-port read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/linear_blend_vertex_skinning.sv =====
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning: four-bone linear blend skinning
// Palette of Q16.16 4x4 matrices in RAM; blends four and transforms a vertex.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_valid/req_ready   | action, slot, element, word, pos, ids, weights
//  rsp     | out | rsp_valid/rsp_ready   | out_x, out_y, out_z, out_w
//
//  A write item is done on acceptance; the next item may follow at once.
//  A skin item takes 64 palette reads (one word per cycle, single read
//  port), then the transform steps, the finish and the output state; the
//  next item is accepted once the sequencer is back in idle.
//  Reset clears control only; the palette is undefined until written.
//  A held result stalls the sequencer in its output cycle; writes are
//  accepted while the sequencer is idle.
module linear_blend_vertex_skinning (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  logic [6:0]          req_bone_slot,
   input  logic [3:0]          req_element,
   input  logic signed [31:0]  req_word_value,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic [27:0]         req_bone_ids,
   input  logic [63:0]         req_weights,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_out_x,
   output logic signed [31:0]  rsp_out_y,
   output logic signed [31:0]  rsp_out_z,
   output logic signed [31:0]  rsp_out_w
);
   import lbs_pkg::*;

   state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;          // read: {k,e}; xform: step
   logic        rd_vld_ff;
   logic [5:0]  rd_tag_ff;
   logic        rd_oob_ff;
   logic signed [31:0] pos_ff [3];
   logic [27:0] ids_ff;
   logic [63:0] wts_ff;
   logic signed [35:0] acc_ff [16];
   logic signed [31:0] blend_ff [16];
   logic signed [OACC_W-1:0] oacc_ff [4];
   logic signed [63:0] prod_ff;
   logic        prod_vld_ff;
   logic [1:0]  prod_row_ff;
   logic signed [31:0] out_ff [4];
   logic        rsp_valid_ff;

   logic        wr_en;
   logic [PAL_AW-1:0] wr_addr, rd_addr;
   logic [31:0] rd_data;
   logic [1:0]  rk;
   logic [6:0]  rid;

   assign req_ready = (state_ff == ST_IDLE);
   wire acc_req = req_valid && req_ready;

   assign wr_en   = acc_req && req_action == ACT_WRITE;
   assign wr_addr = {req_bone_slot[SLOT_W-1:0], req_element};
   assign rk      = cnt_ff[5:4];
   assign rid     = ids_ff[7*rk +: 7];
   assign rd_addr = {rid[SLOT_W-1:0], cnt_ff[3:0]};

   lbs_ram #(.WIDTH(WORD_W), .DEPTH(PAL_DEPTH)) u_pal (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(req_word_value),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (acc_req && req_action == ACT_SKIN)
               state_in = ST_READ;
         end
         ST_READ: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_XFORM;
               cnt_in   = '0;
            end
         end
         ST_XFORM: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd13)
               state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_OUT;
         ST_OUT: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         rd_vld_ff   <= (state_ff == ST_READ);
         prod_vld_ff <= (state_ff == ST_XFORM) && cnt_ff >= 6'd2;
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   logic signed [16:0] wk;
   logic signed [48:0] wprod;
   logic signed [31:0] bsel, psel;
   logic [3:0] xstep;
   logic [1:0] xc, xr;
   assign wk    = {1'b0, wts_ff[16*rd_tag_ff[5:4] +: 16]};
   assign wprod = wk * $signed(rd_data);
   // xform step 0 lands the last read, step 1 latches the blend
   assign xstep = cnt_ff[3:0] - 4'd2;
   assign xc    = xstep[3:2];
   assign xr    = xstep[1:0];
   assign bsel  = blend_ff[{xc, xr}];
   assign psel  = pos_ff[xc];

   always_ff @(posedge clock) begin
      rd_tag_ff <= cnt_ff;
      rd_oob_ff <= {1'b0, rid} >= (ID_W + 1)'(MAX_BONES);
      if (acc_req) begin
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
         ids_ff    <= req_bone_ids;
         wts_ff    <= req_weights;
         for (int i = 0; i < 16; i++)
            acc_ff[i] <= '0;
      end
      if (rd_vld_ff && !rd_oob_ff)
         acc_ff[rd_tag_ff[3:0]] <= acc_ff[rd_tag_ff[3:0]] + 36'(wprod >>> 15);
      if (state_ff == ST_XFORM && cnt_ff == 6'd1) begin
         for (int i = 12; i < 16; i++)
            oacc_ff[i-12] <= OACC_W'(sat32(OACC_W'(acc_ff[i])));
         for (int i = 0; i < 16; i++)
            blend_ff[i] <= sat32(OACC_W'(acc_ff[i]));
      end
      if (state_ff == ST_XFORM && cnt_ff >= 6'd2) begin
         prod_ff     <= bsel * psel;
         prod_row_ff <= xr;
      end
      if (prod_vld_ff)
         oacc_ff[prod_row_ff] <= oacc_ff[prod_row_ff] + OACC_W'(prod_ff >>> 16);
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready))
         for (int i = 0; i < 4; i++)
            out_ff[i] <= sat32(oacc_ff[i]);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];
   assign rsp_out_w = out_ff[3];

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_OUT) else $error("result without sequence");
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == ST_IDLE) else $error("palette write while busy");
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_XFORM |-> !rd_vld_ff || cnt_ff == 6'd0) else $error("late read");
endmodule

// ===== tb/linear_blend_vertex_skinning_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_tb: self-checking bench for four-bone skinning
// Fills part of the bone palette, then sends directed and random palette
// writes and skin items with random idling on both channels. A scoreboard
// predicts each skinned vertex from its own copy of the palette.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_tb;
   import lbs_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int N_RANDOM       = 1300;

   typedef struct packed {
      logic signed [31:0] x, y, z, w;
   } vertex_type;

   class skin_scoreboard;
      logic signed [31:0] palette [PAL_DEPTH];
      vertex_type         vertex_q [$];
      int                 mismatches = 0;

      function longint clamp_q16(longint v);
         if (v > 64'sd2147483647)
            return 64'sd2147483647;
         if (v < -64'sd2147483648)
            return -64'sd2147483648;
         return v;
      endfunction

      function void note_item(logic act, logic [6:0] slot, logic [3:0] elem,
                              logic signed [31:0] word, logic signed [31:0] px,
                              logic signed [31:0] py, logic signed [31:0] pz,
                              logic [27:0] ids, logic [63:0] wts);
         longint     blend [16];
         longint     pos [3];
         longint     acc, m, wk;
         int         id;
         vertex_type v;
         if (act == ACT_WRITE) begin
            palette[slot * 16 + elem] = word;
            return;
         end
         pos[0] = px;
         pos[1] = py;
         pos[2] = pz;
         for (int e = 0; e < 16; e++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) begin
               id  = ids[7 * k +: 7];
               wk  = longint'(wts[16 * k +: 16]);
               m   = (id < MAX_BONES) ? longint'(palette[id * 16 + e]) : 0;
               acc += (wk * m) >>> 15;
            end
            blend[e] = clamp_q16(acc);
         end
         for (int r = 0; r < 4; r++) begin
            acc = blend[12 + r];
            for (int c = 0; c < 3; c++)
               acc += (blend[c * 4 + r] * pos[c]) >>> 16;
            acc = clamp_q16(acc);
            case (r)
               0: v.x = acc[31:0];
               1: v.y = acc[31:0];
               2: v.z = acc[31:0];
               default: v.w = acc[31:0];
            endcase
         end
         vertex_q = {vertex_q, v};
      endfunction

      function void check_vertex(vertex_type got);
         vertex_type exp_v;
         if (vertex_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected vertex x=%h y=%h z=%h w=%h",
                        got.x, got.y, got.z, got.w);
            return;
         end
         exp_v = vertex_q.pop_front();
         if (exp_v != got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("vertex mismatch exp %h %h %h %h got %h %h %h %h",
                        exp_v.x, exp_v.y, exp_v.z, exp_v.w,
                        got.x, got.y, got.z, got.w);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid, req_ready;
   logic               req_action;
   logic [6:0]         req_bone_slot;
   logic [3:0]         req_element;
   logic signed [31:0] req_word_value, req_pos_x, req_pos_y, req_pos_z;
   logic [27:0]        req_bone_ids;
   logic [63:0]        req_weights;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;

   skin_scoreboard sb = new();
   int  idle_cycles = 0;
   int  stall_left  = 0;
   bit  calm_mode   = 0;

   linear_blend_vertex_skinning dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // acceptance and checking
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_item(req_action, req_bone_slot, req_element, req_word_value,
                         req_pos_x, req_pos_y, req_pos_z, req_bone_ids, req_weights);
         if (rsp_valid && rsp_ready)
            sb.check_vertex('{rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function int gap_len();
      if (calm_mode)
         return 0;
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(20, 120);
      return $urandom_range(0, 3);
   endfunction

   // receiver stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= gap_len();
      end
   end

   task automatic send_item(logic act, logic [6:0] slot, logic [3:0] elem,
                            logic [31:0] word, logic [31:0] px, logic [31:0] py,
                            logic [31:0] pz, logic [27:0] ids, logic [63:0] wts);
      int gap;
      req_valid      <= 1'b1;
      req_action     <= act;
      req_bone_slot  <= slot;
      req_element    <= elem;
      req_word_value <= word;
      req_pos_x      <= px;
      req_pos_y      <= py;
      req_pos_z      <= pz;
      req_bone_ids   <= ids;
      req_weights    <= wts;
      do @(posedge clock); while (!req_ready);
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_word(int slot, int elem, logic [31:0] word);
      send_item(ACT_WRITE, slot[6:0], elem[3:0], word, $urandom, $urandom,
                $urandom, 28'($urandom), {$urandom, $urandom});
   endtask

   task automatic skin(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                       logic [27:0] ids, logic [63:0] wts);
      send_item(ACT_SKIN, 7'($urandom), 4'($urandom), $urandom, px, py, pz, ids, wts);
   endtask

   // palette slots that are filled and that skin items draw from
   function logic [6:0] fill_slot(int i);
      return (i < 8) ? 7'(i) : 7'(112 + i);
   endfunction

   function logic [27:0] rand_ids();
      logic [27:0] ids;
      for (int k = 0; k < 4; k++)
         ids[7 * k +: 7] = fill_slot($urandom_range(0, 15));
      return ids;
   endfunction

   function logic [31:0] rand_pos();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
         default: return $urandom_range(0, 32'h0007ffff) - 32'h00040000;
      endcase
   endfunction

   function logic [63:0] rand_weights();
      logic [63:0] w;
      if ($urandom_range(0, 3) == 0)
         return {$urandom, $urandom};
      for (int k = 0; k < 4; k++)
         w[16 * k +: 16] = 16'($urandom_range(0, 16'h2000));
      return w;
   endfunction

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_action     = ACT_WRITE;
      req_bone_slot  = '0;
      req_element    = '0;
      req_word_value = '0;
      req_pos_x      = '0;
      req_pos_y      = '0;
      req_pos_z      = '0;
      req_bone_ids   = '0;
      req_weights    = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the slots that skin items use
      calm_mode = 1;
      for (int s = 0; s < 16; s++)
         for (int e = 0; e < 16; e++)
            write_word(int'(fill_slot(s)), e,
                       (e % 5 == 0) ? 32'h00010000 + $urandom_range(0, 32'h3fff)
                                    : $urandom_range(0, 32'h1ffff) - 32'h10000);
      calm_mode = 0;

      // directed: identity, all-max and all-min bones
      for (int e = 0; e < 16; e++) begin
         write_word(0, e, (e % 5 == 0) ? 32'h00010000 : 32'h0);
         write_word(1, e, 32'h7fffffff);
         write_word(2, e, 32'h80000000);
      end
      skin(32'h7fffffff, 32'h80000000, 32'h00010000, 28'h0, 64'h0000_0000_0000_8000);
      skin(32'h80000000, 32'h7fffffff, 32'hffffffff, 28'h0, 64'h0);
      skin(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, {7'd1, 7'd1, 7'd1, 7'd1},
           64'hffff_ffff_ffff_ffff);
      skin(32'h80000000, 32'h80000000, 32'h80000000, {7'd2, 7'd2, 7'd2, 7'd2},
           64'hffff_ffff_ffff_ffff);
      skin(32'h00010000, 32'h00020000, 32'h00030000, {7'd1, 7'd2, 7'd0, 7'd127},
           64'h8000_8000_8000_8000);
      skin(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 28'hfffffff,
           64'h0001_0001_0001_0001);

      calm_mode = 1;
      for (int i = 0; i < 40; i++)
         skin(rand_pos(), rand_pos(), rand_pos(), rand_ids(), rand_weights());
      calm_mode = 0;

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 2) begin
            req_valid <= 1'b0;
            wait (sb.vertex_q.size() == 0);
         end
         if ($urandom_range(0, 9) < 4)
            write_word($urandom_range(0, MAX_BONES - 1), $urandom_range(0, 15),
                       ($urandom_range(0, 7) == 0) ? $urandom
                          : $urandom_range(0, 32'h3ffff) - 32'h20000);
         else
            skin(rand_pos(), rand_pos(), rand_pos(), rand_ids(), rand_weights());
      end
      req_valid <= 1'b0;

      wait (sb.vertex_q.size() == 0);
      repeat (200) @(posedge clock);
      if (sb.mismatches == 0 && sb.vertex_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
